// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the XMODEM-CRC receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== sv/xmcrc_pkg.sv =====
// Types, protocol codes and the CRC step of the XMODEM-CRC receiver.
package xmcrc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WAIT = 3'd1,
        PH_NUM  = 3'd2,
        PH_COMP = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_ABORT   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_PAYLOAD   = 3'd0,
        VERDICT_COMMIT    = 3'd1,
        VERDICT_DUPLICATE = 3'd2,
        VERDICT_CRC_BAD   = 3'd3,
        VERDICT_END       = 3'd4,
        VERDICT_BAD_COMP  = 3'd5,
        VERDICT_ORDER     = 3'd6,
        VERDICT_START     = 3'd7
    } verdict_t;

    localparam logic       OP_BYTE  = 1'b0;
    localparam logic       OP_START = 1'b1;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [8:0]  COMP_SUM = 9'd255;

    // One byte of CRC-16/XMODEM: MSB first, eight shift steps.
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// ===== sv/xmodem_crc_block_receiver.sv =====
// XMODEM-CRC block receiver: protocol state machine, running CRC and verdicts.
//
// The block takes one received byte (or a session start) per input transaction
// and gives at most one result transaction for it: a tentative payload byte, a
// reply byte to send back to the sender (ACK, NAK or 'C'), or an abort notice,
// each tagged with a verdict and the block number concerned. Items enter an
// input register and are processed in a single pass of combinational logic
// (the phase step and an eight-step CRC-16/XMODEM byte update) into the
// output register, so the block sustains one item per clock cycle unless
// out_stall holds a result. An accepted item waits in the input register and
// its result is then loaded into the output register. The input register
// also serves as a skid stage: while a result waits on out_stall, one more
// item is still taken, and in_stall rises only when both registers are full.
// Payload bytes of a block are passed out before its verdict is known; a
// duplicate, crc-bad or aborted verdict tells the user to discard them.
`include "assert_macros.svh"

module xmodem_crc_block_receiver #(
    parameter int LARGE_BLOCK_BYTES = 1024,
    parameter int SMALL_BLOCK_BYTES = 128
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic [2:0] verdict,
    output logic [7:0] block_seq
);

    // The byte counter must reach the large block size itself.
    localparam int COUNT_W = $clog2(LARGE_BLOCK_BYTES + 1);
    localparam logic [COUNT_W-1:0] LARGE_COUNT = COUNT_W'(LARGE_BLOCK_BYTES);
    localparam logic [COUNT_W-1:0] SMALL_COUNT = COUNT_W'(SMALL_BLOCK_BYTES);

    // Protocol state.
    xmcrc_pkg::phase_t  phase_reg, phase_next;
    logic               large_reg, large_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         last_good_reg, last_good_next;
    logic [7:0]         blk_num_reg, blk_num_next;
    logic [7:0]         comp_reg, comp_next;
    logic [7:0]         crc_high_reg, crc_high_next;

    // Input register (skid stage).
    logic               stage_valid_reg, stage_valid_next;
    logic               stage_op_reg;
    logic [7:0]         stage_byte_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg;
    logic [7:0]         out_value_reg;
    logic [2:0]         out_verdict_reg;
    logic [7:0]         out_blk_reg;

    // Result of the current pass.
    logic               res_valid;
    xmcrc_pkg::kind_t    res_kind;
    logic [7:0]         res_value;
    xmcrc_pkg::verdict_t res_verdict;
    logic [7:0]         res_blk;

    logic               advance;
    logic               fire;
    logic               in_accept;
    logic [COUNT_W-1:0] count_plus;
    logic [COUNT_W-1:0] block_size;
    logic [8:0]         comp_sum;

    // Block checks made on the CRC low byte.
    logic               comp_bad;
    logic               blk_repeat;
    logic               blk_out_of_order;
    logic               crc_mismatch;

    // The output register can take a new result when it is empty or drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = stage_valid_reg && advance;
    assign in_stall  = stage_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign count_plus = count_reg + COUNT_W'(1);
    assign block_size = large_reg ? LARGE_COUNT : SMALL_COUNT;
    assign comp_sum   = {1'b0, blk_num_reg} + {1'b0, comp_reg};

    assign comp_bad         = comp_sum != xmcrc_pkg::COMP_SUM;
    assign blk_repeat       = blk_num_reg == last_good_reg;
    assign blk_out_of_order = blk_num_reg != last_good_reg + 8'd1;
    assign crc_mismatch     = {crc_high_reg, stage_byte_reg} != crc_reg;

    // Next state of the input register.
    always_comb
    begin
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    // Protocol step for the item in the input register: next state.
    always_comb
    begin
        phase_next     = phase_reg;
        large_next     = large_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        last_good_next = last_good_reg;
        blk_num_next   = blk_num_reg;
        comp_next      = comp_reg;
        crc_high_next  = crc_high_reg;

        if (fire) begin
            if (stage_op_reg == xmcrc_pkg::OP_START) begin
                // A start drops any block in progress and requests CRC mode.
                phase_next     = xmcrc_pkg::PH_WAIT;
                last_good_next = 8'h00;
                count_next     = '0;
                crc_next       = 16'h0000;
            end else begin
                unique case (phase_reg)
                    xmcrc_pkg::PH_WAIT:
                    begin
                        if (stage_byte_reg == xmcrc_pkg::B_EOT) begin
                            phase_next = xmcrc_pkg::PH_IDLE;
                        end else if (stage_byte_reg == xmcrc_pkg::B_SOH ||
                                     stage_byte_reg == xmcrc_pkg::B_STX) begin
                            large_next = (stage_byte_reg == xmcrc_pkg::B_STX);
                            count_next = '0;
                            crc_next   = 16'h0000;
                            phase_next = xmcrc_pkg::PH_NUM;
                        end
                    end
                    xmcrc_pkg::PH_NUM:
                    begin
                        blk_num_next = stage_byte_reg;
                        phase_next   = xmcrc_pkg::PH_COMP;
                    end
                    xmcrc_pkg::PH_COMP:
                    begin
                        comp_next  = stage_byte_reg;
                        phase_next = xmcrc_pkg::PH_DATA;
                    end
                    xmcrc_pkg::PH_DATA:
                    begin
                        crc_next = xmcrc_pkg::crc_add(crc_reg, stage_byte_reg);
                        if (count_plus == block_size) begin
                            count_next = '0;
                            phase_next = xmcrc_pkg::PH_CRCH;
                        end else begin
                            count_next = count_plus;
                        end
                    end
                    xmcrc_pkg::PH_CRCH:
                    begin
                        crc_high_next = stage_byte_reg;
                        phase_next    = xmcrc_pkg::PH_CRCL;
                    end
                    xmcrc_pkg::PH_CRCL:
                    begin
                        // Verdict checks in priority order; aborts end the transfer.
                        phase_next = xmcrc_pkg::PH_WAIT;
                        if (comp_bad) begin
                            phase_next = xmcrc_pkg::PH_IDLE;
                        end else if (blk_repeat) begin
                            phase_next = xmcrc_pkg::PH_WAIT;
                        end else if (blk_out_of_order) begin
                            phase_next = xmcrc_pkg::PH_IDLE;
                        end else if (!crc_mismatch) begin
                            last_good_next = blk_num_reg;
                        end
                    end
                    default:
                    begin
                        // Idle: bytes before a session or after its end are dropped.
                    end
                endcase
            end
        end
    end

    // Protocol step for the item in the input register: result.
    always_comb
    begin
        res_valid   = 1'b0;
        res_kind    = xmcrc_pkg::KIND_REPLY;
        res_value   = 8'h00;
        res_verdict = xmcrc_pkg::VERDICT_PAYLOAD;
        res_blk     = 8'h00;

        if (fire) begin
            if (stage_op_reg == xmcrc_pkg::OP_START) begin
                res_valid   = 1'b1;
                res_kind    = xmcrc_pkg::KIND_REPLY;
                res_value   = xmcrc_pkg::B_C;
                res_verdict = xmcrc_pkg::VERDICT_START;
            end else begin
                unique case (phase_reg)
                    xmcrc_pkg::PH_WAIT:
                    begin
                        if (stage_byte_reg == xmcrc_pkg::B_EOT) begin
                            res_valid   = 1'b1;
                            res_kind    = xmcrc_pkg::KIND_REPLY;
                            res_value   = xmcrc_pkg::B_ACK;
                            res_verdict = xmcrc_pkg::VERDICT_END;
                            res_blk     = last_good_reg;
                        end
                    end
                    xmcrc_pkg::PH_DATA:
                    begin
                        res_valid   = 1'b1;
                        res_kind    = xmcrc_pkg::KIND_PAYLOAD;
                        res_value   = stage_byte_reg;
                        res_verdict = xmcrc_pkg::VERDICT_PAYLOAD;
                        res_blk     = blk_num_reg;
                    end
                    xmcrc_pkg::PH_CRCL:
                    begin
                        res_valid = 1'b1;
                        res_blk   = blk_num_reg;
                        if (comp_bad) begin
                            res_kind    = xmcrc_pkg::KIND_ABORT;
                            res_verdict = xmcrc_pkg::VERDICT_BAD_COMP;
                        end else if (blk_repeat) begin
                            res_kind    = xmcrc_pkg::KIND_REPLY;
                            res_value   = xmcrc_pkg::B_ACK;
                            res_verdict = xmcrc_pkg::VERDICT_DUPLICATE;
                        end else if (blk_out_of_order) begin
                            res_kind    = xmcrc_pkg::KIND_ABORT;
                            res_verdict = xmcrc_pkg::VERDICT_ORDER;
                        end else if (crc_mismatch) begin
                            res_kind    = xmcrc_pkg::KIND_REPLY;
                            res_value   = xmcrc_pkg::B_NAK;
                            res_verdict = xmcrc_pkg::VERDICT_CRC_BAD;
                        end else begin
                            res_kind    = xmcrc_pkg::KIND_REPLY;
                            res_value   = xmcrc_pkg::B_ACK;
                            res_verdict = xmcrc_pkg::VERDICT_COMMIT;
                        end
                    end
                    default:
                    begin
                        // Header, number, complement and CRC high bytes give no result.
                    end
                endcase
            end
        end
    end

    // The output register loads whenever it may advance.
    always_comb
    begin
        if (advance)
            out_valid_next = fire && res_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= xmcrc_pkg::PH_IDLE;
            large_reg       <= 1'b0;
            count_reg       <= '0;
            crc_reg         <= 16'h0000;
            last_good_reg   <= 8'h00;
            blk_num_reg     <= 8'h00;
            comp_reg        <= 8'h00;
            crc_high_reg    <= 8'h00;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            large_reg       <= large_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            last_good_reg   <= last_good_next;
            blk_num_reg     <= blk_num_next;
            comp_reg        <= comp_next;
            crc_high_reg    <= crc_high_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            stage_op_reg   <= op;
            stage_byte_reg <= rx_byte;
        end
        if (fire && res_valid) begin
            out_kind_reg    <= res_kind;
            out_value_reg   <= res_value;
            out_verdict_reg <= res_verdict;
            out_blk_reg     <= res_blk;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;
    assign verdict   = out_verdict_reg;
    assign block_seq = out_blk_reg;

    // A payload result always carries the payload verdict.
    `ASSERT_IMPLIES(a_payload_verdict, clk, rst_n,
        out_valid && kind == xmcrc_pkg::KIND_PAYLOAD,
        verdict == xmcrc_pkg::VERDICT_PAYLOAD)
    // Input is held off only while a result is waiting downstream.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid_reg && out_stall)
    // A held item in the skid stage is not lost.
    `ASSERT_NEXT(a_stage_hold, clk, rst_n, stage_valid_reg && !advance, stage_valid_reg)
    // The byte counter only runs inside the payload phase.
    `ASSERT_IMPLIES(a_count_in_data, clk, rst_n,
        phase_reg != xmcrc_pkg::PH_DATA, count_reg == '0)

endmodule
